@@ rtl/ise_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ise_pkg: shared types for the insertion sort engine
// Data word type and width of the sorted values.
// ----------------------------------------------------------------------------
package ise_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;

endpackage

@@ rtl/insertion_sort_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sort_engine: sorted store of signed values with burst readout
// Inserts each incoming value into an ascending store; an item with tlast
// set triggers readout of the whole run, after which the store is empty.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata            | tlast      | tuser
//  ---------+-----+------------------+------------+---------
//  s_*      | in  | value[31:0]      | last       | -
//  m_*      | out | sorted_value     | final_res  | overflow
//
//  Insert: the transfer is taken, then each larger entry moves up one slot
//  in turn, and then the value is placed. A value into an empty store, or
//  one dropped by a full store, needs only the accept step. The single
//  compare and the one-write/one-read store port make the shifts serial.
//  Readout: each result is read, loaded and handed over, plus any stall.
//  s_tready is low while a value is being placed or a run is read out.
//  Reset empties the store at once; no clearing pass is needed.
//  A full store drops new values and flags overflow on that run's readout.
//
module insertion_sort_engine #(
	parameter int CAPACITY = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_tdata: [31:0] value
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  ise_pkg::data_t       s_tdata,
	input  logic                 s_tlast,
	// m_tdata: [31:0] sorted_value
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output ise_pkg::data_t       m_tdata,
	output logic                 m_tlast,
	// m_tuser: [0] overflow
	output logic                 m_tuser
);

	import ise_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_PLACE,
		ST_E_RD,
		ST_E_LOAD,
		ST_E_HOLD
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic            dropped_q;
	logic [AW-1:0]   k_q;
	logic [AW-1:0]   idx_q;
	data_t           value_q;
	logic            last_q;
	logic            valid_q;
	data_t           out_data_q;
	logic            out_last_q;
	logic            out_ovf_q;

	// store and its port signals
	data_t           mem [CAPACITY];
	data_t           rdata_q;
	logic [AW-1:0]   rd_addr;
	logic            we;
	logic [AW-1:0]   wr_addr;
	data_t           wr_data;

	logic            s_xfer;
	logic            m_xfer;
	logic            greater;
	logic            full;
	logic [AW-1:0]   last_idx;

	assign s_tready = (state_q == ST_IDLE);
	assign s_xfer   = s_tvalid && s_tready;
	assign m_xfer   = valid_q && m_tready;
	assign full     = (count_q == CW'(CAPACITY));
	assign greater  = (rdata_q > value_q);
	assign last_idx = AW'(count_q - CW'(1));

	assign m_tvalid = valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	// read address: tail entry on accept, next lower entry while shifting, readout index otherwise
	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = last_idx;
			ST_INS:  rd_addr = k_q - AW'(2);
			default: rd_addr = idx_q;
		endcase
	end

	// write port: shift an entry up, or place the new value
	always_comb begin
		we      = 1'b0;
		wr_addr = k_q;
		wr_data = value_q;
		case (state_q)
			ST_IDLE: begin
				if (s_xfer && count_q == '0) begin
					we      = 1'b1;
					wr_addr = '0;
					wr_data = s_tdata;
				end
			end
			ST_INS: begin
				we      = 1'b1;
				wr_data = greater ? rdata_q : value_q;
			end
			ST_PLACE: we = 1'b1;
			default:  we = 1'b0;
		endcase
	end

	// store
	always_ff @(posedge clk) begin
		if (we)
			mem[wr_addr] <= wr_data;
		rdata_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			valid_q   <= 1'b0;
			k_q       <= '0;
			idx_q     <= '0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_xfer) begin
						value_q <= s_tdata;
						last_q  <= s_tlast;
						idx_q   <= '0;
						k_q     <= AW'(count_q);
						if (full) begin
							dropped_q <= 1'b1;
							state_q   <= s_tlast ? ST_E_RD : ST_IDLE;
						end else if (count_q == '0) begin
							count_q <= count_q + CW'(1);
							state_q <= s_tlast ? ST_E_RD : ST_IDLE;
						end else begin
							state_q <= ST_INS;
						end
					end
				end
				ST_INS: begin
					if (greater && k_q == AW'(1)) begin
						k_q     <= '0;
						state_q <= ST_PLACE;
					end else if (greater) begin
						k_q <= k_q - AW'(1);
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= last_q ? ST_E_RD : ST_IDLE;
					end
				end
				ST_PLACE: begin
					count_q <= count_q + CW'(1);
					state_q <= last_q ? ST_E_RD : ST_IDLE;
				end
				ST_E_RD: state_q <= ST_E_LOAD;
				ST_E_LOAD: begin
					out_data_q <= rdata_q;
					out_last_q <= (idx_q == last_idx);
					out_ovf_q  <= dropped_q;
					valid_q    <= 1'b1;
					state_q    <= ST_E_HOLD;
				end
				ST_E_HOLD: begin
					if (m_xfer) begin
						valid_q <= 1'b0;
						if (out_last_q) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_E_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_valid_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (state_q == ST_E_HOLD))
		else $error("result valid outside hand-over state");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input taken during readout");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("stored count beyond capacity");

	a_empty_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (count_q == '0 && !dropped_q))
		else $error("store not emptied after final result");

endmodule
